### rtl/core/ctc_pkg.sv
// ctc_pkg: shared types, constants and helpers for the columnar transposition cipher
// depends on nothing; used by columnar_transposition_cipher
package ctc_pkg;

  localparam int MAX_COLS = 8;
  localparam int ROWS     = 4;
  localparam int CELLS    = ROWS * MAX_COLS;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = 6;

  localparam logic [7:0] PAD_CHAR = 8'd45;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE         = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS     = 2'd1;
  localparam logic [1:0] CFG_COLUMN_ORDER = 2'd2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [3:0]  NUM_COLS_RST     = 4'd4;
  localparam logic [23:0] COLUMN_ORDER_RST = 24'd16434824;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } ctc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } ctc_out_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } ctc_state_t;

  // source column named at key position pos
  function automatic logic [COL_W-1:0] key_col(input logic [23:0] order,
                                               input logic [COL_W-1:0] pos);
    logic [23:0] sh;
    sh = order >> (5'(pos) * 5'd3);
    return sh[COL_W-1:0];
  endfunction

  // column count clamped to 1..MAX_COLS
  function automatic logic [3:0] eff_cols(input logic [3:0] n);
    logic [3:0] c;
    c = n;
    if (c == 4'd0) begin
      c = 4'd1;
    end
    if (c > 4'(MAX_COLS)) begin
      c = 4'(MAX_COLS);
    end
    return c;
  endfunction

endpackage

### rtl/core/ctc_ram.sv
// ctc_ram: generic single-write, single-read synchronous ram with registered read
// depends on nothing
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/columnar_transposition_cipher.sv
// columnar_transposition_cipher: top level, grid store, load and emission sequencer
// depends on ctc_pkg and ctc_ram
//
// Message bytes are taken one item per clock while busy is low. Encrypt fills a
// 4-row grid row by row; decrypt fills it column by column, each byte going
// straight to the column that column_order names for its key position. Bytes
// past 4 x num_cols are dropped. The item with in_last set starts emission:
// busy stays high while the sequencer reads all 4 x num_cols grid cells
// (effective column count 1..8), one grid cell per cycle, through the single
// read port of the grid ram, and each result appears in the cycle after its read
// on out_data with out_valid high for one cycle. The receiver cannot stall, so
// results must be taken as they appear. Unwritten cells come out as '-'.
// Encrypt emits column by column in key order, decrypt row by row; out_last
// marks the final cell. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and is taken immediately; writes while busy are not supported.
module columnar_transposition_cipher (
  input  logic             clk,
  input  logic             rst_n,
  // item input
  input  logic             start,
  input  ctc_pkg::ctc_in_t in_data,
  output logic             busy,
  // results
  output logic             out_valid,
  output ctc_pkg::ctc_out_t out_data,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_wdata
);

  // configuration registers
  logic        mode_r;
  logic [3:0]  num_cols_r;
  logic [23:0] column_order_r;

  // control state
  ctc_pkg::ctc_state_t state_r, state_nxt;
  logic [ctc_pkg::CNT_W-1:0]  load_count_r, load_count_nxt;
  logic [ctc_pkg::CELLS-1:0]  cell_valid_r, cell_valid_nxt;
  logic [ctc_pkg::COL_W-1:0]  outer_r, outer_nxt;
  logic [ctc_pkg::COL_W-1:0]  inner_r, inner_nxt;

  // read pipeline
  logic out_valid_r, out_last_r, pad_r;

  logic       accept;
  logic       issue;
  logic [3:0] cols;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= ctc_pkg::MODE_ENC;
      num_cols_r     <= ctc_pkg::NUM_COLS_RST;
      column_order_r <= ctc_pkg::COLUMN_ORDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ctc_pkg::CFG_MODE:         mode_r         <= cfg_wdata[0];
        ctc_pkg::CFG_NUM_COLS:     num_cols_r     <= cfg_wdata[3:0];
        ctc_pkg::CFG_COLUMN_ORDER: column_order_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cols   = ctc_pkg::eff_cols(num_cols_r);
  assign accept = start && !busy;

  // ---------------------------------------------------------------- load side
  logic [4:0]                cols2, cols3, row_base;
  logic [ctc_pkg::ROW_W-1:0] enc_row, ld_row;
  logic [ctc_pkg::COL_W-1:0] ld_col;
  logic [ctc_pkg::CNT_W-1:0] enc_rem;
  logic [ctc_pkg::IDX_W-1:0] ld_idx;
  logic                      ld_room, ld_we;

  always_comb begin
    // row = k / cols by comparing with the first multiples of cols (k < 4 x cols)
    cols2   = {cols, 1'b0};
    cols3   = cols2 + 5'(cols);
    enc_row = ctc_pkg::ROW_W'(load_count_r >= 6'(cols))
            + ctc_pkg::ROW_W'(load_count_r >= 6'(cols2))
            + ctc_pkg::ROW_W'(load_count_r >= 6'(cols3));
    case (enc_row)
      2'd1:    row_base = 5'(cols);
      2'd2:    row_base = cols2;
      2'd3:    row_base = cols3;
      default: row_base = 5'd0;
    endcase
    enc_rem = load_count_r - 6'(row_base);

    if (mode_r == ctc_pkg::MODE_ENC) begin
      ld_row = enc_row;
      ld_col = enc_rem[ctc_pkg::COL_W-1:0];
    end else begin
      // decrypt: row is k mod 4, key position k / 4
      ld_row = load_count_r[ctc_pkg::ROW_W-1:0];
      ld_col = ctc_pkg::key_col(column_order_r,
                 load_count_r[ctc_pkg::ROW_W +: ctc_pkg::COL_W]);
    end
    ld_idx  = {ld_row, ld_col};
    ld_room = load_count_r < {cols, 2'b00};
    // a destination column beyond the grid uses up its place but stores nothing
    ld_we   = accept && ld_room && (4'(ld_col) < cols);
  end

  // ---------------------------------------------------------- emission side
  logic [ctc_pkg::COL_W-1:0] inner_max, outer_max;
  logic [ctc_pkg::ROW_W-1:0] rd_row;
  logic [ctc_pkg::COL_W-1:0] rd_col;
  logic [ctc_pkg::IDX_W-1:0] rd_idx;
  logic                      inner_end, issue_last, rd_pad;

  always_comb begin
    if (mode_r == ctc_pkg::MODE_ENC) begin
      // outer walks key positions, inner walks rows
      outer_max = ctc_pkg::COL_W'(cols - 4'd1);
      inner_max = ctc_pkg::COL_W'(ctc_pkg::ROWS - 1);
      rd_row    = inner_r[ctc_pkg::ROW_W-1:0];
      rd_col    = ctc_pkg::key_col(column_order_r, outer_r);
    end else begin
      outer_max = ctc_pkg::COL_W'(ctc_pkg::ROWS - 1);
      inner_max = ctc_pkg::COL_W'(cols - 4'd1);
      rd_row    = outer_r[ctc_pkg::ROW_W-1:0];
      rd_col    = inner_r;
    end
    rd_idx     = {rd_row, rd_col};
    inner_end  = inner_r == inner_max;
    issue_last = inner_end && (outer_r == outer_max);
    rd_pad     = (4'(rd_col) >= cols) || !cell_valid_r[rd_idx];
  end

  // ------------------------------------------------------------- state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctc_pkg::ST_LOAD: begin
        if (accept && in_data.in_last) begin
          state_nxt = ctc_pkg::ST_EMIT;
        end
      end
      ctc_pkg::ST_EMIT: begin
        if (issue_last) begin
          state_nxt = ctc_pkg::ST_LOAD;
        end
      end
      default: state_nxt = ctc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    case (state_r)
      ctc_pkg::ST_LOAD: ;
      ctc_pkg::ST_EMIT: begin
        busy  = 1'b1;
        issue = 1'b1;
      end
      default: ;
    endcase
  end

  // counters and valid bits
  always_comb begin
    load_count_nxt = load_count_r;
    cell_valid_nxt = cell_valid_r;
    outer_nxt      = outer_r;
    inner_nxt      = inner_r;
    if (accept && ld_room) begin
      load_count_nxt = load_count_r + 6'd1;
    end
    if (ld_we) begin
      cell_valid_nxt[ld_idx] = 1'b1;
    end
    if (issue) begin
      if (issue_last) begin
        // grid is free for the next message
        outer_nxt      = '0;
        inner_nxt      = '0;
        load_count_nxt = '0;
        cell_valid_nxt = '0;
      end else if (inner_end) begin
        inner_nxt = '0;
        outer_nxt = outer_r + 3'd1;
      end else begin
        inner_nxt = inner_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctc_pkg::ST_LOAD;
      load_count_r <= '0;
      cell_valid_r <= '0;
      outer_r      <= '0;
      inner_r      <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      cell_valid_r <= cell_valid_nxt;
      outer_r      <= outer_nxt;
      inner_r      <= inner_nxt;
      out_valid_r  <= issue;
      out_last_r   <= issue && issue_last;
    end
  end

  // pad flag travels alongside the ram read
  always_ff @(posedge clk) begin
    pad_r <= rd_pad;
  end

  logic [7:0] grid_rdata;

  ctc_ram #(
    .WIDTH(8),
    .DEPTH(ctc_pkg::CELLS)
  ) u_grid (
    .clk  (clk),
    .we   (ld_we),
    .waddr(ld_idx),
    .wdata(in_data.in_byte),
    .raddr(rd_idx),
    .rdata(grid_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_data.out_byte = pad_r ? ctc_pkg::PAD_CHAR : grid_rdata;
  assign out_data.out_last = out_last_r;

  // ---------------------------------------------------------------- checks
  a_out_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ctc_pkg::ST_EMIT))
    else $error("result without a preceding read");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= ctc_pkg::CNT_W'(ctc_pkg::CELLS))
    else $error("load count beyond grid");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && issue_last) |=> (cell_valid_r == '0 && load_count_r == '0))
    else $error("grid not cleared after emission");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.out_last |-> out_valid)
    else $error("out_last without strobe");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_data.out_last))
    else $error("busy dropped before final item");

endmodule
